// File: sv/b64sd_pkg.sv
// Shared types, constants and the alphabet decode for the Base64 stream decoder.
// No dependencies.
package b64sd_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
    logic       bad_input;
  } data_beat_t;

  // one quad's worth of output work, or one error result
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        last;
    logic        bad;
  } job_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// File: sv/b64sd_front.sv
// Front end: accepts characters, checks framing and padding, assembles quads
// and pushes output jobs. Depends on b64sd_pkg.
module b64sd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  input  b64sd_pkg::text_beat_t text,
  input  logic                q_full,
  output logic                accept,
  output logic                push,
  output b64sd_pkg::job_t     push_job
);
  import b64sd_pkg::*;

  logic [1:0]  pos;
  logic [17:0] acc;
  logic [1:0]  pads;
  logic        discarding;

  logic        last;
  logic        is_pad;
  logic [6:0]  sx;
  logic [5:0]  v6;
  logic [1:0]  pads_eff;
  logic        fail;

  assign accept = text_valid && !q_full;
  assign last   = text.end_of_text;
  assign is_pad = (text.symbol == PAD_CHAR);
  assign sx     = sextet_of(text.symbol);
  assign v6     = is_pad ? 6'd0 : sx[5:0];
  assign pads_eff = is_pad ? 2'(pads + 2'd1) : pads;

  always_comb begin
    if (is_pad) begin
      fail = (pos < 2'd2);
    end else begin
      fail = sx[6] || (pads != 2'd0);
    end
    if (!fail) begin
      if (pos != 2'd3) begin
        fail = last;
      end else begin
        fail = ((pads_eff != 2'd0) && !last) || (pads_eff == 2'd3);
      end
    end
  end

  always_comb begin
    push = 1'b0;
    push_job = '0;
    if (accept && !discarding) begin
      if (fail) begin
        push = 1'b1;
        push_job.nbytes = 2'd1;
        push_job.last = 1'b1;
        push_job.bad = 1'b1;
      end else if (pos == 2'd3) begin
        push = 1'b1;
        push_job.word = {acc, v6};
        push_job.nbytes = 2'(2'd3 - pads_eff);
        push_job.last = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      acc <= '0;
      pads <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      if (discarding) begin
        if (last) begin
          pos <= '0;
          acc <= '0;
          pads <= '0;
          discarding <= 1'b0;
        end
      end else if (fail || pos == 2'd3) begin
        pos <= '0;
        acc <= '0;
        pads <= '0;
        discarding <= fail && !last;
      end else begin
        pos <= pos + 2'd1;
        acc <= {acc[11:0], v6};
        pads <= pads_eff;
      end
    end
  end

endmodule

// File: sv/b64sd_queue.sv
// Short job queue between front end and byte emitter, in flops.
// Depends on b64sd_pkg.
module b64sd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64sd_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output b64sd_pkg::job_t head
);
  import b64sd_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: sv/b64sd_back.sv
// Byte emitter: walks each job's bytes into the output register.
// Depends on b64sd_pkg.
module b64sd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  b64sd_pkg::job_t       head,
  output logic                  pop,
  output logic                  data_valid,
  input  logic                  data_stall,
  output b64sd_pkg::data_beat_t data
);
  import b64sd_pkg::*;

  logic [1:0] k;
  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign load       = !data_valid || !data_stall;
  assign final_byte = (k == 2'(head.nbytes - 2'd1));
  assign pop        = load && not_empty && final_byte;

  always_comb begin
    unique case (k)
      2'd0:    sel_byte = head.word[23:16];
      2'd1:    sel_byte = head.word[15:8];
      default: sel_byte = head.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      k <= '0;
    end else if (load) begin
      data_valid <= not_empty;
      if (not_empty) begin
        k <= final_byte ? 2'd0 : k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && not_empty) begin
      data.data_byte    <= head.bad ? 8'd0 : sel_byte;
      data.end_of_frame <= head.last && final_byte;
      data.bad_input    <= head.bad;
    end
  end

endmodule

// File: sv/base64_stream_decoder_unit.sv
// Top level of the Base64 stream decoder: front end, job queue, byte emitter.
// Depends on b64sd_pkg, b64sd_front, b64sd_queue, b64sd_back.
//
// Decodes standard-alphabet Base64 text, one character per beat, at one
// character per cycle. Every fourth character releases a job of up to three
// bytes (fewer with '=' padding) into a four-entry queue; the emitter sends one
// byte per cycle through a registered output, so the byte side sets the pace
// only while the output is stalled and the queue fills, after which text_stall
// rises. A malformed frame (bad character, misplaced '=', length not a
// multiple of four) gives a single beat with bad_input and end_of_frame set
// and data_byte zero; characters up to the frame's last are then dropped.
// Discard any frame that ends in bad_input.
module base64_stream_decoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  b64sd_pkg::text_beat_t text,
  output logic                  data_valid,
  input  logic                  data_stall,
  output b64sd_pkg::data_beat_t data
);
  import b64sd_pkg::*;

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic q_full;
  logic q_not_empty;
  job_t q_head;

  assign text_stall = q_full;

  b64sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text       (text),
    .q_full     (q_full),
    .accept     (accept),
    .push       (push),
    .push_job   (push_job)
  );

  b64sd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push && accept),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (q_not_empty),
    .head       (q_head),
    .pop        (pop),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data)
  );

endmodule

// File: sv/b64sd_checker.sv
// Port-level checks for the Base64 stream decoder, bound to the top level.
// Depends on b64sd_pkg and base64_stream_decoder_unit.
module b64sd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  data_valid,
  input logic                  data_stall,
  input b64sd_pkg::data_beat_t data
);
  import b64sd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !data_valid)
    else $error("output valid after reset");

  a_bad_closes: assert property (@(posedge clk) disable iff (rst)
    data_valid && data.bad_input |-> data.end_of_frame && data.data_byte == 8'd0)
    else $error("error beat not zero or not closing frame");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_stall |=> data_valid)
    else $error("stalled beat dropped");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_stall |=> $stable(data))
    else $error("stalled beat changed");

endmodule

bind base64_stream_decoder_unit b64sd_checker u_checker (.*);
